>>> src/sfc_pkg.sv
package sfc_pkg;

	// Input item function codes
	localparam logic [1:0] FUNC_BYTE    = 2'd0;
	localparam logic [1:0] FUNC_TICK    = 2'd1;
	localparam logic [1:0] FUNC_BUS_ERR = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_READING = 2'd0;
	localparam logic [1:0] KIND_ALERT   = 2'd1;
	localparam logic [1:0] KIND_EXPIRED = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_CRC  = 2'd1;
	localparam logic [1:0] ERR_BUS  = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_TIMEOUT = 2'd1;

	localparam logic [7:0]  ERR_THRESHOLD_RST = 8'd3;
	localparam logic [15:0] VALID_TIMEOUT_RST = 16'd1000;

	// Frame layout: six bytes
	localparam int FRAME_BYTES = 6;

	// Scaling of raw words to hundredths
	localparam int PROD_W = 31;
	localparam logic [14:0] TEMP_SCALE = 15'd17500;
	localparam logic [14:0] HUM_SCALE  = 15'd12500;
	localparam logic signed [14:0] TEMP_OFFSET = -15'sd4500;
	localparam logic signed [14:0] HUM_OFFSET  = -15'sd600;

	localparam int QUEUE_DEPTH = 4;

	// One queue entry: the results caused by one input item. An optional
	// alert goes first, then an optional main result.
	typedef struct packed {
		logic        alert;
		logic [1:0]  alert_code;
		logic        main;
		logic [1:0]  main_kind;
		logic [1:0]  main_code;
		logic [15:0] temp_raw;
		logic [15:0] hum_alert;
		logic [15:0] hum_main;
		logic        temp_ok;
		logic        hum_ok;
		logic        rd_valid;
	} sfc_entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} sfc_q_stat_t;

endpackage

>>> src/sfc_front.sv
module sfc_front
	import sfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [7:0]            byte_value,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  sfc_q_stat_t           q_stat,
	output logic                  push,
	output sfc_entry_t            push_entry
);

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [2:0] IDX_T_HI  = 3'd0;
	localparam logic [2:0] IDX_T_LO  = 3'd1;
	localparam logic [2:0] IDX_T_CRC = 3'd2;
	localparam logic [2:0] IDX_H_HI  = 3'd3;
	localparam logic [2:0] IDX_H_LO  = 3'd4;
	localparam logic [2:0] IDX_FIRST = 3'(FRAME_BYTES % FRAME_BYTES);

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	logic [7:0]  thr_q;
	logic [15:0] timeout_q;
	logic [2:0]  idx_q, idx_d;
	logic [7:0]  crc_q, crc_d;
	logic [7:0]  hi_q, hi_d;
	logic [7:0]  lo_q, lo_d;
	logic [15:0] temp_q, temp_d;
	logic [15:0] hum_q, hum_d;
	logic        tflag_q, tflag_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [15:0] cd_q, cd_d;

	logic        acc;
	logic [7:0]  cnt_inc;
	logic        alert_hit;
	logic        crc_match;

	assign in_ready  = !q_stat.full;
	assign acc       = in_valid && in_ready;
	assign cnt_inc   = (cnt_q == 8'hFF) ? 8'hFF : cnt_q + 8'd1;
	assign alert_hit = cnt_inc >= thr_q;
	assign crc_match = byte_value == crc_q;

	always_comb begin
		idx_d   = idx_q;
		crc_d   = crc_q;
		hi_d    = hi_q;
		lo_d    = lo_q;
		temp_d  = temp_q;
		hum_d   = hum_q;
		tflag_d = tflag_q;
		cnt_d   = cnt_q;
		cd_d    = cd_q;
		push    = 1'b0;
		push_entry            = '0;
		push_entry.temp_raw   = temp_q;
		push_entry.hum_alert  = hum_q;
		push_entry.hum_main   = hum_q;
		push_entry.rd_valid   = cd_q != 16'd0;
		push_entry.alert_code = ERR_CRC;
		if (acc) begin
			case (func)
				FUNC_BYTE: begin
					case (idx_q)
						IDX_T_HI, IDX_H_HI: begin
							hi_d  = byte_value;
							crc_d = crc8_update(CRC_INIT, byte_value);
							idx_d = idx_q + 3'd1;
						end
						IDX_T_LO, IDX_H_LO: begin
							lo_d  = byte_value;
							crc_d = crc8_update(crc_q, byte_value);
							idx_d = idx_q + 3'd1;
						end
						IDX_T_CRC: begin
							if (!crc_match) begin
								cnt_d = cnt_inc;
								push  = alert_hit;
							end
							push_entry.alert = 1'b1;
							temp_d  = {hi_q, lo_q};
							tflag_d = crc_match;
							crc_d   = CRC_INIT;
							idx_d   = IDX_H_HI;
						end
						default: begin
							// humidity CRC byte closes the frame
							hum_d  = {hi_q, lo_q};
							cnt_d  = 8'd0;
							cd_d   = timeout_q;
							push   = 1'b1;
							push_entry.alert     = !crc_match && alert_hit;
							push_entry.main      = 1'b1;
							push_entry.main_kind = KIND_READING;
							push_entry.main_code = (crc_match && tflag_q) ? ERR_NONE : ERR_CRC;
							push_entry.hum_main  = {hi_q, lo_q};
							push_entry.temp_ok   = tflag_q;
							push_entry.hum_ok    = crc_match;
							push_entry.rd_valid  = timeout_q != 16'd0;
							crc_d  = CRC_INIT;
							idx_d  = IDX_FIRST;
						end
					endcase
				end
				FUNC_TICK: begin
					if (cd_q != 16'd0) begin
						cd_d = cd_q - 16'd1;
						if (cd_q == 16'd1) begin
							push = 1'b1;
							push_entry.main      = 1'b1;
							push_entry.main_kind = KIND_EXPIRED;
							push_entry.main_code = ERR_NONE;
							push_entry.rd_valid  = 1'b0;
						end
					end
				end
				FUNC_BUS_ERR: begin
					cnt_d = cnt_inc;
					push  = alert_hit;
					push_entry.alert      = 1'b1;
					push_entry.alert_code = ERR_BUS;
					idx_d = IDX_FIRST;
					crc_d = CRC_INIT;
				end
				default: begin
					// unused code: drop
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= ERR_THRESHOLD_RST;
			timeout_q <= VALID_TIMEOUT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_ERR_THRESHOLD) begin
				thr_q <= cfg_data[7:0];
			end else if (cfg_index == REG_VALID_TIMEOUT) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= IDX_FIRST;
			crc_q   <= CRC_INIT;
			hi_q    <= 8'd0;
			lo_q    <= 8'd0;
			temp_q  <= 16'd0;
			hum_q   <= 16'd0;
			tflag_q <= 1'b0;
			cnt_q   <= 8'd0;
			cd_q    <= 16'd0;
		end else begin
			idx_q   <= idx_d;
			crc_q   <= crc_d;
			hi_q    <= hi_d;
			lo_q    <= lo_d;
			temp_q  <= temp_d;
			hum_q   <= hum_d;
			tflag_q <= tflag_d;
			cnt_q   <= cnt_d;
			cd_q    <= cd_d;
		end
	end

endmodule

>>> src/sfc_queue.sv
module sfc_queue
	import sfc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sfc_entry_t  push_entry,
	input  logic        pop,
	output sfc_entry_t  head,
	output sfc_q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	sfc_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full      = cnt_q == CNT_W'(DEPTH);
	assign q_stat.not_empty = cnt_q != '0;
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && q_stat.not_empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> src/sfc_back.sv
module sfc_back
	import sfc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  sfc_entry_t         head,
	input  sfc_q_stat_t        q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic [1:0]         fault_code,
	output logic [15:0]        temp_raw,
	output logic [15:0]        humidity_raw,
	output logic signed [14:0] temp_centi_deg,
	output logic signed [14:0] humidity_centi_pct,
	output logic               temp_crc_ok,
	output logic               humidity_crc_ok,
	output logic               reading_valid,
	output logic               last
);

	// floor(p / 65535) for p below 2^31: take p >> 16, then correct once
	function automatic logic [14:0] div_ffff(input logic [PROD_W-1:0] p);
		logic [14:0] q1;
		logic [16:0] r;
		q1 = p[PROD_W-1:16];
		r  = 17'(p[15:0]) + 17'(q1);
		return q1 + 15'(r >= 17'h0FFFF);
	endfunction

	logic phase_q;
	logic en1, en2, take;
	logic cur_alert, cur_last;
	logic [15:0] cur_hum;

	logic              v_s1;
	logic [1:0]        kind_s1, code_s1;
	logic [15:0]       temp_s1, hum_s1;
	logic              tok_s1, hok_s1, rv_s1, last_s1;
	logic [PROD_W-1:0] prod_t_s1, prod_h_s1;

	logic v_s2;

	assign en2  = !v_s2 || out_ready;
	assign en1  = !v_s1 || en2;
	assign take = q_stat.not_empty && en1;

	assign cur_alert = head.alert && !phase_q;
	assign cur_last  = cur_alert ? !head.main : 1'b1;
	assign cur_hum   = cur_alert ? head.hum_alert : head.hum_main;
	assign pop       = take && cur_last;

	// Step through the alert, then the main result of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= !cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= take;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1   <= cur_alert ? KIND_ALERT : head.main_kind;
			code_s1   <= cur_alert ? head.alert_code : head.main_code;
			temp_s1   <= head.temp_raw;
			hum_s1    <= cur_hum;
			tok_s1    <= cur_alert ? 1'b0 : head.temp_ok;
			hok_s1    <= cur_alert ? 1'b0 : head.hum_ok;
			rv_s1     <= head.rd_valid;
			last_s1   <= cur_last;
			prod_t_s1 <= PROD_W'(TEMP_SCALE) * PROD_W'(head.temp_raw);
			prod_h_s1 <= PROD_W'(HUM_SCALE) * PROD_W'(cur_hum);
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			result_kind        <= kind_s1;
			fault_code         <= code_s1;
			temp_raw           <= temp_s1;
			humidity_raw       <= hum_s1;
			temp_centi_deg     <= $signed(div_ffff(prod_t_s1)) + TEMP_OFFSET;
			humidity_centi_pct <= $signed(div_ffff(prod_h_s1)) + HUM_OFFSET;
			temp_crc_ok        <= tok_s1;
			humidity_crc_ok    <= hok_s1;
			reading_valid      <= rv_s1;
			last               <= last_s1;
		end
	end

	assign out_valid = v_s2;

endmodule

>>> src/sensor_frame_crc_checker.sv
// Sensor frame CRC checker.
// Input channel (in_valid/in_ready, func, byte_value): one beat is a frame
// byte, a one millisecond tick or a bus error. A frame is six bytes: temp
// word high/low, its CRC-8 (poly 0x31, init 0xFF), humidity word high/low,
// its CRC-8. Output channel (out_valid/out_ready): one beat per result; a
// humidity CRC failure that reaches the error threshold gives two beats,
// the alert first, with last set only on the final one.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
// error threshold, 1 the validity timeout in ms. cfg_ready is always high;
// write only while the block is idle.
// Throughput: one input beat per cycle while the queue is not full. A
// result passes through the queue write, multiply stage and scale stage
// before it is presented; an item with two results holds the output for
// both of its beats.
// Reset: frame position, CRC, words, error count and validity countdown
// clear; threshold returns to 3 and timeout to 1000; the queue empties.
// Receiver stall: the output register holds, the back pipeline holds, and
// the queue fills; in_ready drops once the queue is full.
module sensor_frame_crc_checker
	import sfc_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [7:0]            byte_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            result_kind,
	output logic [1:0]            fault_code,
	output logic [15:0]           temp_raw,
	output logic [15:0]           humidity_raw,
	output logic signed [14:0]    temp_centi_deg,
	output logic signed [14:0]    humidity_centi_pct,
	output logic                  temp_crc_ok,
	output logic                  humidity_crc_ok,
	output logic                  reading_valid,
	output logic                  last
);

	sfc_q_stat_t q_stat;
	sfc_entry_t  push_entry;
	sfc_entry_t  head;
	logic        push;
	logic        pop;

	// Config writes never stall
	assign cfg_ready = 1'b1;

	// Front: accept beats, run the CRC and counters, classify results
	sfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.byte_value (byte_value),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue: decouple classification from result delivery
	sfc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// Back: expand entries into result beats, scale words to hundredths
	sfc_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head               (head),
		.q_stat             (q_stat),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.result_kind        (result_kind),
		.fault_code         (fault_code),
		.temp_raw           (temp_raw),
		.humidity_raw       (humidity_raw),
		.temp_centi_deg     (temp_centi_deg),
		.humidity_centi_pct (humidity_centi_pct),
		.temp_crc_ok        (temp_crc_ok),
		.humidity_crc_ok    (humidity_crc_ok),
		.reading_valid      (reading_valid),
		.last               (last)
	);

endmodule
